>>> hw/rtl/cld_pkg.sv
// ----------------------------------------------------------------------------
// cld_pkg
// Shared types, constants and saturation helpers for the capped wall force.
// ----------------------------------------------------------------------------
`default_nettype none

package cld_pkg;

    // Fixed-point format
    localparam int FRAC_BITS = 16;

    // Register file
    localparam int REG_W   = 31;
    localparam int ADDR_W  = 5;
    localparam logic [2:0] REG_SIGMA_LEN   = 3'd0;
    localparam logic [2:0] REG_SIGMA_POW6  = 3'd1;
    localparam logic [2:0] REG_WELL_DEPTH  = 3'd2;
    localparam logic [2:0] REG_CUTOFF_SQ   = 3'd3;
    localparam logic [2:0] REG_CAP_DIST    = 3'd4;
    localparam logic [2:0] REG_CAP_DIST_SQ = 3'd5;

    // Divider geometry: 31-bit divisor, 31 quotient bits, one bit per stage
    localparam int DIV_DW    = 31;
    localparam int DIV_QW    = 31;
    localparam int DIV_NW    = DIV_DW + DIV_QW + 1;
    localparam int DIV_STEPS = DIV_QW;

    // Accept edge to the edge that takes the result
    localparam int LATENCY = 3 + 4 * (DIV_STEPS + 1) + 7;

    typedef struct packed {
        logic [REG_W-1:0] sigma_len;
        logic [REG_W-1:0] sigma_pow6;
        logic [REG_W-1:0] well_depth;
        logic [REG_W-1:0] cutoff_sq;
        logic [REG_W-1:0] cap_dist;
        logic [REG_W-1:0] cap_dist_sq;
    } t_cfg;

    // Per-item data that rides along the pipeline
    typedef struct packed {
        logic signed [31:0] sep;
        logic [31:0]        mag;
        logic               outside;
        logic               capped;
        logic [DIV_DW-1:0]  re;
        logic [DIV_DW-1:0]  r06;
        logic signed [31:0] pot;
        logic               fneg;
    } t_side;

    // Signed saturation to 32 bits
    function automatic logic signed [31:0] sat_s(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -66'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return $signed(v[31:0]);
        end
    endfunction

    // Nonnegative quotient saturation
    function automatic logic [DIV_QW-1:0] qsat(input logic ovf, input logic [DIV_QW-1:0] q);
        return ovf ? '1 : q;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cld_regs.sv
// ----------------------------------------------------------------------------
// cld_regs
// APB configuration registers for the capped wall force block.
// ----------------------------------------------------------------------------
`default_nettype none

module cld_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [cld_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output cld_pkg::t_cfg                   o_cfg
);
    import cld_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] w_idx;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sigma_len   <= 31'd65536;
            r_cfg.sigma_pow6  <= 31'd65536;
            r_cfg.well_depth  <= 31'd65536;
            r_cfg.cutoff_sq   <= 31'd82570;
            r_cfg.cap_dist    <= 31'd52429;
            r_cfg.cap_dist_sq <= 31'd41943;
        end else if (w_wr) begin
            case (w_idx)
                REG_SIGMA_LEN:   r_cfg.sigma_len   <= pwdata[REG_W-1:0];
                REG_SIGMA_POW6:  r_cfg.sigma_pow6  <= pwdata[REG_W-1:0];
                REG_WELL_DEPTH:  r_cfg.well_depth  <= pwdata[REG_W-1:0];
                REG_CUTOFF_SQ:   r_cfg.cutoff_sq   <= pwdata[REG_W-1:0];
                REG_CAP_DIST:    r_cfg.cap_dist    <= pwdata[REG_W-1:0];
                REG_CAP_DIST_SQ: r_cfg.cap_dist_sq <= pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_idx)
            REG_SIGMA_LEN:   prdata = {1'b0, r_cfg.sigma_len};
            REG_SIGMA_POW6:  prdata = {1'b0, r_cfg.sigma_pow6};
            REG_WELL_DEPTH:  prdata = {1'b0, r_cfg.well_depth};
            REG_CUTOFF_SQ:   prdata = {1'b0, r_cfg.cutoff_sq};
            REG_CAP_DIST:    prdata = {1'b0, r_cfg.cap_dist};
            REG_CAP_DIST_SQ: prdata = {1'b0, r_cfg.cap_dist_sq};
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/cld_div.sv
// ----------------------------------------------------------------------------
// cld_div
// Pipelined restoring divider, one quotient bit per stage, with overflow flag
// for quotients that do not fit the 31-bit result.
// ----------------------------------------------------------------------------
`default_nettype none

module cld_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_vld,
    input  wire logic [cld_pkg::DIV_NW-1:0] i_num,
    input  wire logic [cld_pkg::DIV_DW-1:0] i_den,
    input  cld_pkg::t_side                  i_side,
    output logic                            o_vld,
    output logic [cld_pkg::DIV_QW-1:0]      o_quo,
    output logic                            o_ovf,
    output cld_pkg::t_side                  o_side
);
    import cld_pkg::*;

    logic              r_vld  [0:DIV_STEPS];
    logic [DIV_DW-1:0] r_rem  [0:DIV_STEPS];
    logic [DIV_QW-1:0] r_num  [0:DIV_STEPS];
    logic [DIV_QW-1:0] r_quo  [0:DIV_STEPS];
    logic [DIV_DW-1:0] r_den  [0:DIV_STEPS];
    logic              r_ovf  [0:DIV_STEPS];
    t_side             r_side [0:DIV_STEPS];

    logic [DIV_DW-1:0] n_rem  [1:DIV_STEPS];
    logic [DIV_QW-1:0] n_num  [1:DIV_STEPS];
    logic [DIV_QW-1:0] n_quo  [1:DIV_STEPS];

    // one quotient bit per stage
    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_stage
        logic [DIV_DW:0] w_try;
        logic            w_ge;
        assign w_try = {r_rem[g], r_num[g][DIV_QW-1]};
        assign w_ge  = w_try >= {1'b0, r_den[g]};
        assign n_rem[g+1] = w_ge ? DIV_DW'(w_try - {1'b0, r_den[g]}) : w_try[DIV_DW-1:0];
        assign n_num[g+1] = {r_num[g][DIV_QW-2:0], 1'b0};
        assign n_quo[g+1] = {r_quo[g][DIV_QW-2:0], w_ge};
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= DIV_STEPS; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_vld;
            for (int i = 1; i <= DIV_STEPS; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    // data chain; overflow when the high part already reaches the divisor
    always_ff @(posedge i_clk) begin
        r_ovf[0]  <= i_num[DIV_NW-1:DIV_QW] >= {1'b0, i_den};
        r_rem[0]  <= i_num[DIV_NW-2:DIV_QW];
        r_num[0]  <= i_num[DIV_QW-1:0];
        r_quo[0]  <= '0;
        r_den[0]  <= i_den;
        r_side[0] <= i_side;
        for (int i = 1; i <= DIV_STEPS; i++) begin
            r_ovf[i]  <= r_ovf[i-1];
            r_rem[i]  <= n_rem[i];
            r_num[i]  <= n_num[i];
            r_quo[i]  <= n_quo[i];
            r_den[i]  <= r_den[i-1];
            r_side[i] <= r_side[i-1];
        end
    end

    assign o_vld  = r_vld[DIV_STEPS];
    assign o_quo  = r_quo[DIV_STEPS];
    assign o_ovf  = r_ovf[DIV_STEPS];
    assign o_side = r_side[DIV_STEPS];

endmodule

`default_nettype wire

>>> hw/rtl/capped_lj_wall_force.sv
// Throughput: one transaction per cycle; busy is low except during reset.
// Depth is set by four 32-register dividers (input register plus 31 quotient
// stages) plus the square, multiply and output stages.
// Reset (synchronous, active low) empties the pipeline and restores registers.
// The receiver cannot stall: each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
// capped_lj_wall_force
// Capped WCA Lennard-Jones wall force and potential, fully pipelined.
// ----------------------------------------------------------------------------
`default_nettype none

module capped_lj_wall_force (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic signed [31:0]         i_separation,
    output logic                            o_valid,
    output logic signed [31:0]              o_force_z,
    output logic signed [31:0]              o_potential,
    output logic                            o_outside_cutoff,
    output logic                            o_capped,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [cld_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import cld_pkg::*;

    localparam int R2_W = 64 - FRAC_BITS;

    t_cfg cfg;

    logic r_busy;
    logic r_v0, r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8;

    logic signed [31:0] r_sep0, r_sep1;
    logic [31:0]        r_mag1;
    logic [63:0]        r_sq;
    t_side              r_s2, r_s3, r_s4, r_s5, r_s6, r_s7, r_s8;
    logic [61:0]        r_r12p;
    logic signed [31:0] r_t1, r_t2;
    logic signed [63:0] r_p1, r_p2;
    logic signed [31:0] r_k5, r_k6;
    logic signed [31:0] r_coef, r_pot0, r_pot0b;
    logic signed [63:0] r_fp, r_pp;
    logic [DIV_NW-1:0]  r_fmag;

    cld_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign busy = r_busy;

    // input side: separation magnitude
    logic [31:0] w_mag0;
    assign w_mag0 = r_sep0[31] ? 32'(-r_sep0) : r_sep0;

    // classify: cutoff, cap, effective square
    logic [R2_W-1:0]   w_r2;
    logic              w_capped;
    logic [DIV_DW-1:0] w_re_raw;
    t_side             w_s2;
    always_comb begin
        w_r2     = r_sq[63:FRAC_BITS];
        w_capped = w_r2 < R2_W'(cfg.cap_dist_sq);
        w_re_raw = w_capped ? cfg.cap_dist_sq : w_r2[DIV_DW-1:0];
        w_s2         = '0;
        w_s2.sep     = r_sep1;
        w_s2.mag     = r_mag1;
        w_s2.outside = w_r2 >= R2_W'(cfg.cutoff_sq);
        w_s2.capped  = w_capped;
        w_s2.re      = (w_re_raw == '0) ? DIV_DW'(1) : w_re_raw;
    end

    // three chained Q divides give sigma^6 / re^3
    logic              d1_vld, d2_vld, d3_vld, d4_vld;
    logic [DIV_QW-1:0] d1_q, d2_q, d3_q, d4_q;
    logic              d1_ovf, d2_ovf, d3_ovf, d4_ovf;
    t_side             d1_s, d2_s, d3_s, d4_s;

    cld_div u_div1 (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_vld (r_v2),
        .i_num (DIV_NW'(cfg.sigma_pow6) << FRAC_BITS),
        .i_den (r_s2.re), .i_side (r_s2),
        .o_vld (d1_vld), .o_quo (d1_q), .o_ovf (d1_ovf), .o_side (d1_s)
    );

    cld_div u_div2 (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_vld (d1_vld),
        .i_num (DIV_NW'(qsat(d1_ovf, d1_q)) << FRAC_BITS),
        .i_den (d1_s.re), .i_side (d1_s),
        .o_vld (d2_vld), .o_quo (d2_q), .o_ovf (d2_ovf), .o_side (d2_s)
    );

    cld_div u_div3 (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_vld (d2_vld),
        .i_num (DIV_NW'(qsat(d2_ovf, d2_q)) << FRAC_BITS),
        .i_den (d2_s.re), .i_side (d2_s),
        .o_vld (d3_vld), .o_quo (d3_q), .o_ovf (d3_ovf), .o_side (d3_s)
    );

    // coefficient and potential arithmetic
    logic [DIV_QW-1:0]  w_r06;
    t_side              w_s3;
    logic signed [31:0] w_r12, w_r06s;
    logic signed [31:0] w_eps, w_e4, w_k;
    logic signed [31:0] w_pot1, w_pot;
    logic               w_fneg;
    t_side              w_s8;
    always_comb begin
        w_r06    = qsat(d3_ovf, d3_q);
        w_s3     = d3_s;
        w_s3.r06 = w_r06;

        w_r12  = sat_s($signed({4'b0, r_r12p}) >>> FRAC_BITS);
        w_r06s = $signed({1'b0, r_s3.r06});

        w_eps = $signed({1'b0, cfg.well_depth});
        w_e4  = sat_s(66'(w_eps) * 66'sd4);
        w_k   = sat_s(66'($signed({1'b0, cfg.cap_dist})) - 66'($signed({1'b0, r_s4.mag}))
                      + 66'($signed({1'b0, cfg.sigma_len})));

        w_pot1 = r_s7.capped ? sat_s(66'(r_pp) >>> FRAC_BITS) : r_pot0b;
        w_pot  = sat_s(66'(w_pot1) + 66'(w_eps));
        w_fneg = r_fp < 0;
        w_s8      = r_s7;
        w_s8.pot  = w_pot;
        w_s8.fneg = w_fneg;
    end

    // force divide by the effective square
    cld_div u_div4 (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_vld (r_v8),
        .i_num (r_fmag),
        .i_den (r_s8.re), .i_side (r_s8),
        .o_vld (d4_vld), .o_quo (d4_q), .o_ovf (d4_ovf), .o_side (d4_s)
    );

    // result assembly with sign and saturation
    logic signed [31:0] w_force;
    always_comb begin
        if (d4_ovf) begin
            w_force = d4_s.fneg ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else if (d4_s.fneg) begin
            w_force = -$signed({1'b0, d4_q});
        end else begin
            w_force = $signed({1'b0, d4_q});
        end
    end

    // control: valid bits and busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_v5    <= 1'b0;
            r_v6    <= 1'b0;
            r_v7    <= 1'b0;
            r_v8    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_busy  <= 1'b0;
            r_v0    <= start && !r_busy;
            r_v1    <= r_v0;
            r_v2    <= r_v1;
            r_v3    <= d3_vld;
            r_v4    <= r_v3;
            r_v5    <= r_v4;
            r_v6    <= r_v5;
            r_v7    <= r_v6;
            r_v8    <= r_v7;
            o_valid <= d4_vld;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        // accept and square
        r_sep0 <= i_separation;
        r_sep1 <= r_sep0;
        r_mag1 <= w_mag0;
        r_sq   <= w_mag0 * w_mag0;
        r_s2   <= w_s2;
        // r12 product
        r_s3   <= w_s3;
        r_r12p <= w_r06 * w_r06;
        // bracket terms
        r_s4 <= r_s3;
        r_t1 <= sat_s(66'(w_r12) * 66'sd12 - 66'(w_r06s) * 66'sd6);
        r_t2 <= sat_s(66'(w_r12) - 66'(w_r06s));
        // scale by 4*eps
        r_s5 <= r_s4;
        r_p1 <= w_e4 * r_t1;
        r_p2 <= w_e4 * r_t2;
        r_k5 <= w_k;
        // Q shift back
        r_s6   <= r_s5;
        r_coef <= sat_s(66'(r_p1) >>> FRAC_BITS);
        r_pot0 <= sat_s(66'(r_p2) >>> FRAC_BITS);
        r_k6   <= r_k5;
        // force numerator and cap scaling
        r_s7    <= r_s6;
        r_fp    <= r_coef * r_s6.sep;
        r_pp    <= r_pot0 * r_k6;
        r_pot0b <= r_pot0;
        // final potential, force magnitude
        r_s8   <= w_s8;
        r_fmag <= DIV_NW'(w_fneg ? -r_fp : r_fp);
        // outputs
        o_outside_cutoff <= d4_s.outside;
        o_capped         <= d4_s.capped && !d4_s.outside;
        o_force_z        <= d4_s.outside ? 32'sd0 : w_force;
        o_potential      <= d4_s.outside ? 32'sd0 : d4_s.pot;
    end

endmodule

`default_nettype wire

>>> hw/rtl/cld_chk.sv
// ----------------------------------------------------------------------------
// cld_chk
// Port-level checks for the capped wall force block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cld_chk (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic                       o_valid,
    input wire logic signed [31:0]         o_force_z,
    input wire logic signed [31:0]         o_potential,
    input wire logic                       o_outside_cutoff,
    input wire logic                       o_capped
);
    import cld_pkg::*;

    // every accepted transaction yields a result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LATENCY o_valid)
        else $error("result missing after accepted transaction");

    // no result without a matching accepted transaction
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result without transaction");

    // outside the cutoff nothing acts
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_outside_cutoff |-> o_force_z == 0 && o_potential == 0 && !o_capped)
        else $error("nonzero result outside cutoff");

endmodule

bind capped_lj_wall_force cld_chk u_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_valid          (o_valid),
    .o_force_z        (o_force_z),
    .o_potential      (o_potential),
    .o_outside_cutoff (o_outside_cutoff),
    .o_capped         (o_capped)
);

`default_nettype wire
